// File: src/cbsc_pkg.sv
// Shared types and codes for the CBOR subset stream checker.
// No dependencies; imported by every module of the block except cbsc_in_stage.
`timescale 1ns / 1ps

package cbsc_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEAD    = 2'd0,
        PH_EXT     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_IDLE    = 2'd3
    } t_phase;

    // Byte roles
    localparam logic [1:0] ROLE_HEAD    = 2'd0;
    localparam logic [1:0] ROLE_EXT     = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    // Major types
    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    // Additional info values
    localparam logic [4:0] INFO_FALSE  = 5'd20;
    localparam logic [4:0] INFO_TRUE   = 5'd21;
    localparam logic [4:0] INFO_LEN1   = 5'd24;
    localparam logic [4:0] INFO_LEN2   = 5'd25;
    localparam logic [4:0] INFO_BADMIN = 5'd26;

    // Error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TOO_DEEP  = 4'd1;
    localparam logic [3:0] ERR_NEG_TAG   = 4'd2;
    localparam logic [3:0] ERR_SIMPLE    = 4'd3;
    localparam logic [3:0] ERR_LEN_FORM  = 4'd4;
    localparam logic [3:0] ERR_ITEMS     = 4'd5;
    localparam logic [3:0] ERR_KEY       = 4'd6;
    localparam logic [3:0] ERR_TRUNCATED = 4'd7;
    localparam logic [3:0] ERR_TRAILING  = 4'd8;

    localparam logic [5:0] MAX_ITEMS_RESET = 6'd32;

    // Per-byte result
    typedef struct packed {
        logic [3:0]  error_code;
        logic        accepted;
        logic        verdict_valid;
        logic [2:0]  values_closed;
        logic [2:0]  nest_level;
        logic [15:0] argument;
        logic        head_done;
        logic        is_key;
        logic [2:0]  major_type;
        logic [1:0]  byte_role;
    } t_result;

endpackage

// File: src/cbsc_in_stage.sv
// Input register of the CBOR subset stream checker.
// Depends on nothing but the clock and reset; feeds cbsc_parser.
`timescale 1ns / 1ps

module cbsc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;

    // Take a new transaction when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;

    // Hold the accepted byte until the parser consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last_byte = r_last_byte;

endmodule

// File: src/cbsc_parser.sv
// Parser state and per-byte decode of the CBOR subset stream checker.
// Uses cbsc_pkg; one byte is decoded and the state updated per advance.
`timescale 1ns / 1ps

module cbsc_parser #(
    parameter int MAX_NEST = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [5:0]      i_max_items,
    output cbsc_pkg::t_result o_result
);

    import cbsc_pkg::*;

    localparam int DEPTH = MAX_NEST + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int OW    = $clog2(DEPTH + 1);

    typedef logic [MAX_NEST:0][6:0] t_items;
    typedef logic [MAX_NEST:0]      t_flags;

    t_phase      r_phase,        n_phase;
    logic [2:0]  r_pend_major,   n_pend_major;
    logic        r_pend_key,     n_pend_key;
    logic [15:0] r_len,          n_len;
    logic [1:0]  r_ext_left,     n_ext_left;
    logic [15:0] r_pay_left,     n_pay_left;
    logic [OW-1:0] r_open,       n_open;
    t_items      r_items,        n_items;
    t_flags      r_is_map,       n_is_map;
    logic        r_top_done,     n_top_done;
    logic [3:0]  r_sticky,       n_sticky;

    // Next item opens a key when the innermost container is a map at an even count
    function automatic logic next_key(input logic [OW-1:0] open, input t_items items,
                                      input t_flags is_map);
        logic [IW-1:0] t;
        t = IW'(open - OW'(1));
        return (open != '0) && is_map[t] && !items[t][0];
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEAD;
            r_pend_major <= '0;
            r_pend_key   <= 1'b0;
            r_len        <= '0;
            r_ext_left   <= '0;
            r_pay_left   <= '0;
            r_open       <= '0;
            r_items      <= '0;
            r_is_map     <= '0;
            r_top_done   <= 1'b0;
            r_sticky     <= ERR_NONE;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_pend_major <= n_pend_major;
            r_pend_key   <= n_pend_key;
            r_len        <= n_len;
            r_ext_left   <= n_ext_left;
            r_pay_left   <= n_pay_left;
            r_open       <= n_open;
            r_items      <= n_items;
            r_is_map     <= n_is_map;
            r_top_done   <= n_top_done;
            r_sticky     <= n_sticky;
        end
    end

    // Decode one byte, complete heads, close finished containers
    always_comb begin
        logic        k;
        logic [4:0]  info;
        logic [2:0]  mt;
        logic        act_complete;
        logic [2:0]  c_major;
        logic [15:0] c_arg;
        logic        c_key;
        logic        act_fin;
        logic        fin_key;
        logic        do_check;
        logic        go;
        logic [3:0]  raise_code;
        logic [1:0]  ext_dec;
        logic [15:0] pay_dec;
        logic [IW-1:0] top;
        logic [3:0]  verdict_err;

        n_phase      = r_phase;
        n_pend_major = r_pend_major;
        n_pend_key   = r_pend_key;
        n_len        = r_len;
        n_ext_left   = r_ext_left;
        n_pay_left   = r_pay_left;
        n_open       = r_open;
        n_items      = r_items;
        n_is_map     = r_is_map;
        n_top_done   = r_top_done;
        n_sticky     = r_sticky;

        o_result     = '0;
        o_result.byte_role = ROLE_IGNORED;

        k            = next_key(r_open, r_items, r_is_map);
        info         = i_data_byte[4:0];
        mt           = i_data_byte[7:5];
        act_complete = 1'b0;
        c_major      = r_pend_major;
        c_arg        = '0;
        c_key        = r_pend_key;
        act_fin      = 1'b0;
        fin_key      = 1'b0;
        do_check     = 1'b0;
        go           = 1'b0;
        raise_code   = ERR_NONE;
        ext_dec      = (r_ext_left != 2'd0) ? r_ext_left - 2'd1 : 2'd0;
        pay_dec      = (r_pay_left != 16'd0) ? r_pay_left - 16'd1 : 16'd0;
        top          = IW'(r_open);
        verdict_err  = ERR_NONE;

        case (r_phase)
            PH_HEAD: begin
                o_result.byte_role  = ROLE_HEAD;
                o_result.major_type = mt;
                o_result.is_key     = k;
                o_result.nest_level = 3'(r_open);
                n_pend_major        = mt;
                n_pend_key          = k;
                if (k && mt != MT_TEXT) begin
                    raise_code = ERR_KEY;
                end else if (!k && (mt == MT_NEGINT || mt == MT_TAG)) begin
                    raise_code = ERR_NEG_TAG;
                end else if (!k && mt == MT_SIMPLE && info != INFO_FALSE &&
                             info != INFO_TRUE) begin
                    raise_code = ERR_SIMPLE;
                end else if (info >= INFO_BADMIN) begin
                    raise_code = ERR_LEN_FORM;
                end else if (info < INFO_LEN1) begin
                    act_complete = 1'b1;
                    c_major      = mt;
                    c_arg        = {11'd0, info};
                    c_key        = k;
                end else begin
                    n_len      = '0;
                    n_ext_left = (info == INFO_LEN1) ? 2'd1 : 2'd2;
                    n_phase    = PH_EXT;
                end
            end
            PH_EXT: begin
                o_result.byte_role  = ROLE_EXT;
                o_result.major_type = r_pend_major;
                o_result.is_key     = r_pend_key;
                o_result.nest_level = 3'(r_open);
                n_len               = {r_len[7:0], i_data_byte};
                n_ext_left          = ext_dec;
                if (ext_dec == 2'd0) begin
                    act_complete = 1'b1;
                    c_arg        = n_len;
                end
            end
            PH_PAYLOAD: begin
                o_result.byte_role  = ROLE_PAYLOAD;
                o_result.major_type = r_pend_major;
                o_result.is_key     = r_pend_key;
                o_result.nest_level = 3'(r_open);
                n_pay_left          = pay_dec;
                if (pay_dec == 16'd0) begin
                    act_fin = 1'b1;
                    fin_key = r_pend_key;
                end
            end
            default: begin
                if (r_sticky == ERR_NONE && r_top_done) begin
                    raise_code = ERR_TRAILING;
                end
            end
        endcase

        // Complete a decoded head
        if (act_complete) begin
            o_result.head_done = 1'b1;
            o_result.argument  = c_arg;
            if (c_key || c_major == MT_BYTES || c_major == MT_TEXT) begin
                if (c_arg == 16'd0) begin
                    act_fin = 1'b1;
                    fin_key = c_key;
                end else begin
                    n_pay_left = c_arg;
                    n_phase    = PH_PAYLOAD;
                end
            end else if (c_major == MT_ARRAY || c_major == MT_MAP) begin
                if (c_arg > {10'd0, i_max_items}) begin
                    raise_code = ERR_ITEMS;
                end else if (c_arg == 16'd0) begin
                    act_fin = 1'b1;
                end else if (r_open > OW'(MAX_NEST)) begin
                    raise_code = ERR_TOO_DEEP;
                end else begin
                    // Push a new container level
                    n_items[top]  = (c_major == MT_MAP) ? {c_arg[5:0], 1'b0}
                                                        : {1'b0, c_arg[5:0]};
                    n_is_map[top] = (c_major == MT_MAP);
                    n_open        = r_open + OW'(1);
                    n_phase       = PH_HEAD;
                    do_check      = 1'b1;
                end
            end else begin
                act_fin = 1'b1;
            end
        end

        // Finish an item and close every container it completes
        if (act_fin) begin
            o_result.values_closed = 3'd1;
            if (fin_key) begin
                if (r_open != '0 && r_items[IW'(r_open - OW'(1))] != 7'd0) begin
                    n_items[IW'(r_open - OW'(1))] = r_items[IW'(r_open - OW'(1))] - 7'd1;
                end
            end else begin
                go = (r_open != '0);
                for (int i = MAX_NEST; i >= 0; i--) begin
                    if (go && n_open == OW'(i + 1)) begin
                        if (n_items[i] != 7'd0) begin
                            n_items[i] = n_items[i] - 7'd1;
                        end
                        if (n_items[i] != 7'd0) begin
                            go = 1'b0;
                        end else begin
                            n_open = n_open - OW'(1);
                            o_result.values_closed = o_result.values_closed + 3'd1;
                        end
                    end
                end
                if (n_open == '0) begin
                    n_top_done = 1'b1;
                end
            end
            n_phase  = n_top_done ? PH_IDLE : PH_HEAD;
            do_check = 1'b1;
        end

        // Depth check: a value would have to start beyond the bound
        if (do_check && !n_top_done && !next_key(n_open, n_items, n_is_map) &&
            n_open > OW'(MAX_NEST)) begin
            raise_code = ERR_TOO_DEEP;
        end

        // Latch the first error and stop parsing
        if (raise_code != ERR_NONE) begin
            if (n_sticky == ERR_NONE) begin
                n_sticky = raise_code;
            end
            n_phase = PH_IDLE;
        end

        // Verdict on the last byte, then restart
        if (i_last_byte) begin
            if (n_sticky != ERR_NONE) begin
                verdict_err = n_sticky;
            end else if (!n_top_done) begin
                verdict_err = ERR_TRUNCATED;
            end
            o_result.verdict_valid = 1'b1;
            o_result.error_code    = verdict_err;
            o_result.accepted      = (verdict_err == ERR_NONE);
            n_phase      = PH_HEAD;
            n_pend_major = '0;
            n_pend_key   = 1'b0;
            n_len        = '0;
            n_ext_left   = '0;
            n_pay_left   = '0;
            n_open       = '0;
            n_items      = '0;
            n_is_map     = '0;
            n_top_done   = 1'b0;
            n_sticky     = ERR_NONE;
        end
    end

endmodule

// File: src/cbsc_out_stage.sv
// Result register of the CBOR subset stream checker.
// Uses cbsc_pkg for the result type; drives the output stream.
`timescale 1ns / 1ps

module cbsc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cbsc_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output cbsc_pkg::t_result o_result
);

    import cbsc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Slot is free when empty or when the held transaction leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: src/cbor_subset_stream_checker.sv
// Path: a byte is accepted into the input register, then its decoded result is loaded into
// the result register, which drives the output.
// Throughput: one byte per cycle; while a result waits at the output one more byte is held
// in the input register, then the input stalls. Each byte is decoded and the nesting
// counters closed in one pass of the parser logic.
// Reset: synchronous, active low; clears the parser, empties both registers, max_items 32.
`timescale 1ns / 1ps

module cbor_subset_stream_checker #(
    parameter int MAX_NEST = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,   // max_items
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // last_byte
    // per-byte results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] major_type, [3] is_key, [4] head_done, [20:5] argument, [23:21] nest_level,
    // [26:24] values_closed, [27] accepted, [31:28] error_code
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,    // [1:0] byte_role
    output logic        m_axis_tlast     // verdict_valid
);

    import cbsc_pkg::*;

    logic [5:0] r_max_items_q;
    logic       w_in_valid;
    logic [7:0] w_byte;
    logic       w_last;
    logic       w_out_free;
    logic       w_advance;
    t_result    w_result;
    t_result    w_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_items_q <= MAX_ITEMS_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_items_q <= i_cfg_wr_data;
        end
    end

    assign w_advance   = w_in_valid && w_out_free;

    cbsc_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_advance   (w_advance),
        .o_valid     (w_in_valid),
        .o_data_byte (w_byte),
        .o_last_byte (w_last)
    );

    cbsc_parser #(
        .MAX_NEST (MAX_NEST)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_data_byte (w_byte),
        .i_last_byte (w_last),
        .i_max_items (r_max_items_q),
        .o_result    (w_result)
    );

    cbsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out)
    );

    // Pack the result transaction
    assign m_axis_tdata = {w_out.error_code, w_out.accepted, w_out.values_closed,
                           w_out.nest_level, w_out.argument, w_out.head_done,
                           w_out.is_key, w_out.major_type};
    assign m_axis_tuser = w_out.byte_role;
    assign m_axis_tlast = w_out.verdict_valid;

endmodule

// File: src/cbsc_checker.sv
// Port-level checks for the CBOR subset stream checker.
// Uses cbsc_pkg codes; bound to cbor_subset_stream_checker below.
`timescale 1ns / 1ps

module cbsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    import cbsc_pkg::*;

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Verdict fields stay clear away from the last byte
    a_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:27] == 5'd0)
        else $error("verdict fields set without a last byte");

    // Accept exactly when no error is reported
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[27] == (m_axis_tdata[31:28] == ERR_NONE))
        else $error("accepted disagrees with error code");

    // Ignored bytes carry no head information
    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ROLE_IGNORED |-> m_axis_tdata[26:0] == 27'd0)
        else $error("ignored byte carries head fields");

    // Argument is zero unless a head completes
    a_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[20:5] == 16'd0)
        else $error("argument without completed head");

endmodule

bind cbor_subset_stream_checker cbsc_checker u_cbsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
